/* rtl/core/dprsdf_pkg.sv */
// ----------------------------------------------------------------------------
// dprsdf_pkg
// Shared types and constants of the dual pulse rate speed/direction framer.
// ----------------------------------------------------------------------------
package dprsdf_pkg;

	// Sizing
	localparam int MAX_SLOTS     = 64;
	localparam int COUNT_BITS    = 16;
	localparam int SLOT_BITS     = $clog2(MAX_SLOTS);
	localparam int USE_BITS      = 7;
	localparam int WIN_BITS      = $clog2(MAX_SLOTS + 1);
	localparam int CMP_BITS      = (WIN_BITS > USE_BITS) ? WIN_BITS : USE_BITS;
	localparam int TIMER_BITS    = 16;
	localparam int PULSE_BITS    = 4;
	localparam int BYTE_BITS     = 8;
	localparam int HIST_BITS     = 2 * COUNT_BITS;

	// Frame queue between front and back
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOT_TICKS   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_UPLOAD_TICKS = 2'd2;

	localparam logic [TIMER_BITS-1:0] RST_SLOT_TICKS   = 16'd100;
	localparam logic [USE_BITS-1:0]   RST_SLOTS_IN_USE = 7'd50;
	localparam logic [TIMER_BITS-1:0] RST_UPLOAD_TICKS = 16'd100;

	// Frame bytes
	localparam logic [BYTE_BITS-1:0] SYNC0 = 8'hAA;
	localparam logic [BYTE_BITS-1:0] SYNC1 = 8'h55;

	localparam int POS_BITS = 3;
	localparam logic [POS_BITS-1:0] POS_SYNC0 = 3'd0;
	localparam logic [POS_BITS-1:0] POS_SYNC1 = 3'd1;
	localparam logic [POS_BITS-1:0] POS_SPEED = 3'd2;
	localparam logic [POS_BITS-1:0] POS_DIR   = 3'd3;
	localparam logic [POS_BITS-1:0] POS_CHECK = 3'd4;

	typedef struct packed {
		logic [BYTE_BITS-1:0] speed;
		logic [BYTE_BITS-1:0] dir;
	} frame_t;

	typedef struct packed {
		logic   vld;
		frame_t data;
	} frame_push_t;

	typedef struct packed {
		logic [FIFO_CNT_BITS-1:0] level;
		logic                     avail;
	} fifo_stat_t;

endpackage

/* rtl/core/dprsdf_ram.sv */
// ----------------------------------------------------------------------------
// dprsdf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dprsdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, old data on a same-edge write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/dprsdf_fifo.sv */
// ----------------------------------------------------------------------------
// dprsdf_fifo
// Short frame queue between the tick front end and the byte serializer.
// ----------------------------------------------------------------------------
module dprsdf_fifo import dprsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_push_t in_frame,
	input  logic        pop,
	output frame_t      head,
	output fifo_stat_t  stat
);

	frame_t                   ent_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wptr_q;
	logic [FIFO_PTR_BITS-1:0] rptr_q;
	logic [FIFO_CNT_BITS-1:0] level_q;
	logic                     do_pop;

	assign do_pop     = pop && (level_q != '0);
	assign head       = ent_q[rptr_q];
	assign stat.level = level_q;
	assign stat.avail = (level_q != '0);

	// Entry storage
	always_ff @(posedge clk) begin
		if (in_frame.vld) begin
			ent_q[wptr_q] <= in_frame.data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (in_frame.vld) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (in_frame.vld && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (!in_frame.vld && do_pop) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/dprsdf_front.sv */
// ----------------------------------------------------------------------------
// dprsdf_front
// Tick front end: counts, timers, slot ring and rates, frame requests.
// ----------------------------------------------------------------------------
module dprsdf_front import dprsdf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [PULSE_BITS-1:0]    pulses_a,
	input  logic [PULSE_BITS-1:0]    pulses_b,
	input  logic                     link_ready,
	output logic                     full,
	input  logic                     cfg_wr,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  fifo_stat_t               fifo_stat,
	output frame_push_t              frame_push
);

	// Configuration
	logic [TIMER_BITS-1:0] slot_ticks_q;
	logic [USE_BITS-1:0]   slots_use_q;
	logic [TIMER_BITS-1:0] upload_ticks_q;

	// Tick state
	logic [COUNT_BITS-1:0] count_a_q, count_b_q;
	logic [COUNT_BITS-1:0] rate_a_q, rate_b_q;
	logic [TIMER_BITS-1:0] slot_tmr_q, upl_tmr_q;
	logic [SLOT_BITS-1:0]  slot_idx_q;
	logic [MAX_SLOTS-1:0]  hist_vld_q;

	// Stage 1
	logic                  vld_s1, upl_s1, slot_s1, rdy_s1;
	logic [SLOT_BITS-1:0]  addr_s1;
	logic [COUNT_BITS-1:0] cnt_a_s1, cnt_b_s1;

	// Write-to-read bypass for the ring
	logic                  fwd_vld_q;
	logic [SLOT_BITS-1:0]  fwd_addr_q;
	logic [HIST_BITS-1:0]  fwd_data_q;

	logic                  accept;
	logic [COUNT_BITS-1:0] cnt_a_nx, cnt_b_nx;
	logic [TIMER_BITS-1:0] upl_inc, slot_inc;
	logic                  upl_hit, slot_hit;
	logic [CMP_BITS-1:0]   use_ext, win, idx_ext, cur_ext, cur_p1;
	logic [SLOT_BITS-1:0]  cur_idx, nxt_idx;
	logic [HIST_BITS-1:0]  rd_data, hist, wr_data;
	logic                  wr_en;
	logic [COUNT_BITS-1:0] old_a, old_b;
	logic [COUNT_BITS-1:0] rmin, spd;
	logic signed [COUNT_BITS:0] dif, dir;
	logic                  pend;
	logic [FIFO_CNT_BITS:0] need;

	// Accept and space check: one frame may still be in stage 1
	assign pend   = vld_s1 && upl_s1 && rdy_s1;
	assign need   = {1'b0, fifo_stat.level} + (FIFO_CNT_BITS+1)'(pend);
	assign full   = (need >= (FIFO_CNT_BITS+1)'(FIFO_DEPTH));
	assign accept = push && !full;

	// Counts and timers
	assign cnt_a_nx = count_a_q + COUNT_BITS'(pulses_a);
	assign cnt_b_nx = count_b_q + COUNT_BITS'(pulses_b);
	assign upl_inc  = upl_tmr_q + 1'b1;
	assign slot_inc = slot_tmr_q + 1'b1;
	assign upl_hit  = (upl_inc >= upload_ticks_q);
	assign slot_hit = (slot_inc >= slot_ticks_q);

	// Window size and ring index
	always_comb begin
		use_ext = CMP_BITS'(slots_use_q);
		if (use_ext == '0) begin
			win = CMP_BITS'(1);
		end else if (use_ext > CMP_BITS'(MAX_SLOTS)) begin
			win = CMP_BITS'(MAX_SLOTS);
		end else begin
			win = use_ext;
		end
		idx_ext = CMP_BITS'(slot_idx_q);
		cur_ext = (idx_ext >= win) ? '0 : idx_ext;
		cur_idx = cur_ext[SLOT_BITS-1:0];
		cur_p1  = cur_ext + 1'b1;
		nxt_idx = (cur_p1 >= win) ? '0 : cur_p1[SLOT_BITS-1:0];
	end

	// History ring, both channels in one word
	dprsdf_ram #(
		.WIDTH(HIST_BITS),
		.DEPTH(MAX_SLOTS)
	) u_hist (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(wr_data),
		.rd_en  (accept && slot_hit),
		.rd_addr(cur_idx),
		.rd_data(rd_data)
	);

	// Stage 1: old count lookup, never-written slots read as zero
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			hist = fwd_data_q;
		end else if (hist_vld_q[addr_s1]) begin
			hist = rd_data;
		end else begin
			hist = '0;
		end
		old_a   = hist[HIST_BITS-1:COUNT_BITS];
		old_b   = hist[COUNT_BITS-1:0];
		wr_en   = vld_s1 && slot_s1;
		wr_data = {cnt_a_s1, cnt_b_s1};
	end

	// Stage 1: speed and direction from the rates before this slot update
	always_comb begin
		rmin = (rate_a_q < rate_b_q) ? rate_a_q : rate_b_q;
		spd  = (rmin != '0) ? rmin - 1'b1 : '0;
		dif  = $signed({1'b0, rate_a_q}) - $signed({1'b0, rate_b_q});
		if (dif >= 2) begin
			dir = dif - (COUNT_BITS+1)'(2);
		end else if (dif <= -2) begin
			dir = dif + (COUNT_BITS+1)'(2);
		end else begin
			dir = '0;
		end
		frame_push.vld        = pend;
		frame_push.data.speed = spd[BYTE_BITS-1:0];
		frame_push.data.dir   = dir[BYTE_BITS-1:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ticks_q   <= RST_SLOT_TICKS;
			slots_use_q    <= RST_SLOTS_IN_USE;
			upload_ticks_q <= RST_UPLOAD_TICKS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SLOT_TICKS:   slot_ticks_q   <= cfg_data[TIMER_BITS-1:0];
				REG_SLOTS_IN_USE: slots_use_q    <= cfg_data[USE_BITS-1:0];
				REG_UPLOAD_TICKS: upload_ticks_q <= cfg_data[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Tick state update on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			upl_tmr_q  <= '0;
			slot_tmr_q <= '0;
			slot_idx_q <= '0;
		end else if (accept) begin
			count_a_q  <= cnt_a_nx;
			count_b_q  <= cnt_b_nx;
			upl_tmr_q  <= upl_hit ? '0 : upl_inc;
			slot_tmr_q <= slot_hit ? '0 : slot_inc;
			if (slot_hit) begin
				slot_idx_q <= nxt_idx;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			upl_s1   <= upl_hit;
			slot_s1  <= slot_hit;
			rdy_s1   <= link_ready;
			addr_s1  <= cur_idx;
			cnt_a_s1 <= cnt_a_nx;
			cnt_b_s1 <= cnt_b_nx;
		end
	end

	// Rates, slot valid bits and bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_a_q   <= '0;
			rate_b_q   <= '0;
			hist_vld_q <= '0;
			fwd_vld_q  <= 1'b0;
		end else begin
			fwd_vld_q <= wr_en;
			if (wr_en) begin
				rate_a_q            <= cnt_a_s1 - old_a;
				rate_b_q            <= cnt_b_s1 - old_b;
				hist_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wr_data;
		end
	end

endmodule

/* rtl/core/dprsdf_back.sv */
// ----------------------------------------------------------------------------
// dprsdf_back
// Frame serializer: turns queued frames into five bytes with an output register.
// ----------------------------------------------------------------------------
module dprsdf_back import dprsdf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frame_t               head,
	input  fifo_stat_t           fifo_stat,
	output logic                 fifo_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [BYTE_BITS-1:0] frame_byte,
	output logic                 frame_last
);

	frame_t               frm_q;
	logic                 frm_vld_q;
	logic [POS_BITS-1:0]  pos_q;
	logic                 out_vld_q;
	logic [BYTE_BITS-1:0] out_byte_q;
	logic                 out_last_q;

	logic                 take;
	logic                 adv;
	logic                 done;
	logic [BYTE_BITS-1:0] nxt_byte;

	assign take     = pop && out_vld_q;
	assign adv      = frm_vld_q && (!out_vld_q || take);
	assign done     = adv && (pos_q == POS_CHECK);
	assign fifo_pop = fifo_stat.avail && (!frm_vld_q || done);

	assign empty      = !out_vld_q;
	assign frame_byte = out_byte_q;
	assign frame_last = out_last_q;

	// Byte select
	always_comb begin
		unique case (pos_q)
			POS_SYNC0: nxt_byte = SYNC0;
			POS_SYNC1: nxt_byte = SYNC1;
			POS_SPEED: nxt_byte = frm_q.speed;
			POS_DIR:   nxt_byte = frm_q.dir;
			POS_CHECK: nxt_byte = SYNC0 ^ SYNC1 ^ frm_q.speed ^ frm_q.dir;
			default:   nxt_byte = '0;
		endcase
	end

	// Frame holding register and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_vld_q <= 1'b0;
			pos_q     <= POS_SYNC0;
		end else if (fifo_pop) begin
			frm_vld_q <= 1'b1;
			pos_q     <= POS_SYNC0;
		end else if (done) begin
			frm_vld_q <= 1'b0;
		end else if (adv) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			frm_q <= head;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= nxt_byte;
			out_last_q <= (pos_q == POS_CHECK);
		end
	end

endmodule

/* rtl/core/dual_pulse_rate_speed_direction_framer.sv */
// ----------------------------------------------------------------------------
// dual_pulse_rate_speed_direction_framer
// Two-channel pulse rate meter that uploads speed/direction frames.
// ----------------------------------------------------------------------------
// One tick word is taken per clock cycle whenever full is low. The front end
// folds the tick into the counts and timers on the accept edge; in the next
// cycle it does the slot update against the 64-entry history RAM (registered
// read, with a bypass for back-to-back slot updates on the same entry) and
// builds any speed/direction frame. Frames wait in a four-deep queue; the
// serializer sends each as five byte words (AA, 55, speed, direction, xor),
// one per cycle of pop, through an output register. full rises only while
// that queue, counting a frame still being built, has no room. The history
// ring needs no clearing pass: per-entry valid bits cleared by reset make
// unwritten entries read as zero. Configuration writes are always ready.
module dual_pulse_rate_speed_direction_framer import dprsdf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [PULSE_BITS-1:0]    pulses_a,
	input  logic [PULSE_BITS-1:0]    pulses_b,
	input  logic                     link_ready,
	output logic                     empty,
	input  logic                     pop,
	output logic [BYTE_BITS-1:0]     frame_byte,
	output logic                     frame_last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	frame_push_t frame_push;
	fifo_stat_t  fifo_stat;
	frame_t      head;
	logic        fifo_pop;

	assign cfg_ready = 1'b1;

	// Tick front end
	dprsdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pulses_a  (pulses_a),
		.pulses_b  (pulses_b),
		.link_ready(link_ready),
		.full      (full),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_stat (fifo_stat),
		.frame_push(frame_push)
	);

	// Frame queue
	dprsdf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_frame(frame_push),
		.pop     (fifo_pop),
		.head    (head),
		.stat    (fifo_stat)
	);

	// Byte serializer
	dprsdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.fifo_pop  (fifo_pop),
		.pop       (pop),
		.empty     (empty),
		.frame_byte(frame_byte),
		.frame_last(frame_last)
	);

endmodule

/* rtl/core/dprsdf_chk.sv */
// ----------------------------------------------------------------------------
// dprsdf_chk
// Port-level checks on the frame byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module dprsdf_chk import dprsdf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [BYTE_BITS-1:0] frame_byte,
	input logic                 frame_last
);

	logic [POS_BITS-1:0]  pos_q;
	logic [BYTE_BITS-1:0] acc_q;
	logic                 take;

	assign take = pop && !empty;

	// Track byte position and running xor within a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_SYNC0;
			acc_q <= '0;
		end else if (take) begin
			if (pos_q == POS_CHECK) begin
				pos_q <= POS_SYNC0;
				acc_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				acc_q <= acc_q ^ frame_byte;
			end
		end
	end

	a_sync0: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pos_q == POS_SYNC0) |-> (frame_byte == SYNC0))
		else $error("frame does not open with first sync byte");

	a_sync1: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pos_q == POS_SYNC1) |-> (frame_byte == SYNC1))
		else $error("second frame byte is not the sync byte");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (frame_last == (pos_q == POS_CHECK)))
		else $error("frame_last not on the fifth byte");

	a_check: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pos_q == POS_CHECK) |-> (frame_byte == acc_q))
		else $error("checksum byte mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte)))
		else $error("waiting word changed before pop");

endmodule

bind dual_pulse_rate_speed_direction_framer dprsdf_chk u_chk (.*);
